// ===== rtl/z80pd_pkg.sv =====
// Shared types and constants for the Z80 instruction predecoder.
package z80pd_pkg;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'd0,
		PH_PREFIX = 3'd1,
		PH_CB     = 3'd2,
		PH_CBOP   = 3'd3,
		PH_ED     = 3'd4,
		PH_DISP   = 3'd5,
		PH_IMMLO  = 3'd6,
		PH_IMMHI  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		GRP_MAIN = 2'd0,
		GRP_CB   = 2'd1,
		GRP_ED   = 2'd2
	} group_t;

	localparam logic [7:0] BYTE_DD = 8'hDD;
	localparam logic [7:0] BYTE_FD = 8'hFD;
	localparam logic [7:0] BYTE_CB = 8'hCB;
	localparam logic [7:0] BYTE_ED = 8'hED;

	localparam logic [4:0] RG_NONE = 5'd0;
	localparam logic [4:0] RG_C    = 5'd2;
	localparam logic [4:0] RG_HLI  = 5'd7;
	localparam logic [4:0] RG_A    = 5'd8;
	localparam logic [4:0] RG_F    = 5'd9;
	localparam logic [4:0] RG_BC   = 5'd16;
	localparam logic [4:0] RG_DE   = 5'd17;
	localparam logic [4:0] RG_HL   = 5'd18;
	localparam logic [4:0] RG_SP   = 5'd19;
	localparam logic [4:0] RG_AF   = 5'd20;
	localparam logic [4:0] RG_AFX  = 5'd21;

	localparam logic [0:0] ADDR_START = 1'd0;

	typedef struct packed {
		logic [6:0]  form;
		logic [4:0]  opa;
		logic [4:0]  opb;
		logic [3:0]  sub;
		logic [15:0] imm;
		logic [7:0]  disp;
		logic        rel;
	} dec_t;

	function automatic logic [4:0] ixreg(input logic [1:0] pfx);
		return (pfx == 2'd2) ? 5'd15 : 5'd12;
	endfunction

	function automatic logic [4:0] reg8(input logic [2:0] y, input logic [1:0] pfx);
		if (pfx != 2'd0 && y >= 3'd4 && y <= 3'd5)
			return ((pfx == 2'd2) ? 5'd13 : 5'd10) + {4'd0, y[0]};
		return 5'd1 + {2'd0, y};
	endfunction

	function automatic logic [4:0] rpair(input logic [1:0] p, input logic [1:0] pfx,
			input logic af);
		if (p == 2'd2 && pfx != 2'd0) return ixreg(pfx);
		if (p == 2'd3) return af ? RG_AF : RG_SP;
		return RG_BC + {3'd0, p};
	endfunction

	// bits 1:0 immediate byte count, bit 2 displacement byte
	function automatic logic [2:0] need_main(input logic [7:0] op, input logic [1:0] pfx);
		logic [1:0] x;
		logic [2:0] y, z, d;
		x = op[7:6]; y = op[5:3]; z = op[2:0];
		d = (pfx != 2'd0) ? 3'd4 : 3'd0;
		case (x)
			2'd0: begin
				case (z)
					3'd0: return (y >= 3'd2) ? 3'd1 : 3'd0;
					3'd1: return (!y[0]) ? 3'd2 : 3'd0;
					3'd2: return (y >= 3'd4) ? 3'd2 : 3'd0;
					3'd4, 3'd5: return (y == 3'd6) ? d : 3'd0;
					3'd6: return 3'd1 | ((y == 3'd6) ? d : 3'd0);
					default: return 3'd0;
				endcase
			end
			2'd1: return (y == 3'd6 && z == 3'd6) ? 3'd0 :
				((y == 3'd6 || z == 3'd6) ? d : 3'd0);
			2'd2: return (z == 3'd6) ? d : 3'd0;
			default: begin
				case (z)
					3'd2, 3'd4: return 3'd2;
					3'd3: return (y == 3'd0) ? 3'd2 :
						((y == 3'd2 || y == 3'd3) ? 3'd1 : 3'd0);
					3'd5: return (y == 3'd1) ? 3'd2 : 3'd0;
					3'd6: return 3'd1;
					default: return 3'd0;
				endcase
			end
		endcase
	endfunction

	function automatic logic [2:0] need_ed(input logic [7:0] op);
		return (op[7:6] == 2'd1 && op[2:0] == 3'd3) ? 3'd2 : 3'd0;
	endfunction

	function automatic dec_t decode_main(input logic [7:0] op, input logic [1:0] pfx,
			input logic [7:0] d, input logic [15:0] imm);
		dec_t r;
		logic [1:0] x, p;
		logic [2:0] y, z;
		logic q, aw;
		logic [4:0] hl, src;
		x = op[7:6]; y = op[5:3]; z = op[2:0]; q = y[0]; p = y[2:1];
		hl = (pfx != 2'd0) ? ixreg(pfx) : RG_HL;
		r = '0;
		case (x)
			2'd0: begin
				case (z)
					3'd0: begin
						if (y == 3'd1) begin
							r.form = 7'd1; r.opa = RG_AF; r.opb = RG_AFX;
						end else if (y != 3'd0) begin
							r.form = (y == 3'd2) ? 7'd2 : ((y == 3'd3) ? 7'd3 : 7'd4);
							if (y >= 3'd4) r.sub = {2'd0, y[1:0]};
							r.disp = imm[7:0]; r.rel = 1'b1;
						end
					end
					3'd1: begin
						if (!q) begin
							r.form = 7'd5; r.opa = rpair(p, pfx, 1'b0); r.imm = imm;
						end else if (pfx != 2'd0) begin
							r.form = 7'd82; r.opa = hl; r.opb = rpair(p, pfx, 1'b0);
						end else begin
							r.form = 7'd6; r.opa = RG_HL; r.opb = rpair(p, 2'd0, 1'b0);
						end
					end
					3'd2: begin
						case (y)
							3'd0: begin r.form = 7'd7; r.opa = RG_BC; r.opb = RG_A; end
							3'd1: begin r.form = 7'd8; r.opa = RG_A; r.opb = RG_BC; end
							3'd2: begin r.form = 7'd9; r.opa = RG_DE; r.opb = RG_A; end
							3'd3: begin r.form = 7'd10; r.opa = RG_A; r.opb = RG_DE; end
							3'd4: begin
								r.form = (pfx != 2'd0) ? 7'd84 : 7'd11; r.opa = hl; r.imm = imm;
							end
							3'd5: begin
								r.form = (pfx != 2'd0) ? 7'd83 : 7'd12; r.opa = hl; r.imm = imm;
							end
							3'd6: begin r.form = 7'd13; r.opa = RG_A; r.imm = imm; end
							default: begin r.form = 7'd14; r.opa = RG_A; r.imm = imm; end
						endcase
					end
					3'd3: begin
						r.form = q ? 7'd16 : 7'd15; r.opa = rpair(p, pfx, 1'b0);
					end
					3'd4, 3'd5: begin
						if (y == 3'd6 && pfx != 2'd0) begin
							r.form = z[0] ? 7'd86 : 7'd85; r.opa = hl; r.disp = d;
						end else if (y == 3'd6) begin
							r.form = z[0] ? 7'd110 : 7'd109; r.opa = RG_HLI;
						end else begin
							r.form = z[0] ? 7'd18 : 7'd17; r.opa = reg8(y, pfx);
						end
					end
					3'd6: begin
						r.imm = imm;
						if (y == 3'd6 && pfx != 2'd0) begin
							r.form = 7'd87; r.opa = hl; r.disp = d;
						end else if (y == 3'd6) begin
							r.form = 7'd106; r.opa = RG_HLI;
						end else begin
							r.form = 7'd19; r.opa = reg8(y, pfx);
						end
					end
					default: r.form = 7'd20 + {4'd0, y};
				endcase
			end
			2'd1: begin
				if (y == 3'd6 && z == 3'd6) r.form = 7'd29;
				else if (pfx != 2'd0 && y == 3'd6) begin
					r.form = 7'd88; r.opa = hl; r.opb = reg8(z, 2'd0); r.disp = d;
				end else if (pfx != 2'd0 && z == 3'd6) begin
					r.form = 7'd89; r.opa = reg8(y, 2'd0); r.opb = hl; r.disp = d;
				end else begin
					r.form = 7'd28; r.opa = reg8(y, pfx); r.opb = reg8(z, pfx);
					if (pfx == 2'd0 && y == 3'd6) r.form = 7'd107;
					if (pfx == 2'd0 && z == 3'd6) r.form = 7'd108;
				end
			end
			2'd2: begin
				src = (pfx != 2'd0 && z == 3'd6) ? hl : reg8(z, pfx);
				aw = (y == 3'd0 || y == 3'd1 || y == 3'd3);
				r.form = aw ? 7'd31 : 7'd30; r.sub = {1'b0, y};
				if (pfx != 2'd0 && z == 3'd6) begin
					r.form = r.form + 7'd60; r.disp = d;
				end
				if (aw) begin r.opa = RG_A; r.opb = src; end
				else r.opa = src;
			end
			default: begin
				case (z)
					3'd0: begin r.form = 7'd32; r.sub = {1'b0, y}; end
					3'd1: begin
						if (!q) begin r.form = 7'd33; r.opa = rpair(p, pfx, 1'b1); end
						else if (p == 2'd0) r.form = 7'd34;
						else if (p == 2'd1) r.form = 7'd35;
						else if (p == 2'd2) begin
							r.form = (pfx != 2'd0) ? 7'd92 : 7'd36; r.opa = hl;
						end else begin r.form = 7'd37; r.opa = RG_SP; r.opb = hl; end
					end
					3'd2: begin r.form = 7'd38; r.sub = {1'b0, y}; r.imm = imm; end
					3'd3: begin
						case (y)
							3'd0: begin r.form = 7'd39; r.imm = imm; end
							3'd2: begin r.form = 7'd40; r.opa = RG_A; r.imm = imm; end
							3'd3: begin r.form = 7'd41; r.opa = RG_A; r.imm = imm; end
							3'd4: begin
								r.form = (pfx != 2'd0) ? 7'd94 : 7'd42; r.opa = RG_SP; r.opb = hl;
							end
							3'd5: begin r.form = 7'd43; r.opa = RG_DE; r.opb = RG_HL; end
							3'd6: r.form = 7'd44;
							3'd7: r.form = 7'd45;
							default: r.form = 7'd0;
						endcase
					end
					3'd4: begin r.form = 7'd46; r.sub = {1'b0, y}; r.imm = imm; end
					3'd5: begin
						if (!q) begin r.form = 7'd47; r.opa = rpair(p, pfx, 1'b1); end
						else if (p == 2'd0) begin r.form = 7'd48; r.imm = imm; end
					end
					3'd6: begin r.form = 7'd49; r.sub = {1'b0, y}; r.imm = imm; end
					default: begin
						r.form = 7'd51; r.sub = {1'b0, y}; r.imm = {10'd0, y, 3'd0};
					end
				endcase
			end
		endcase
		return r;
	endfunction

	function automatic dec_t decode_cb(input logic [7:0] op, input logic [1:0] pfx,
			input logic [7:0] d);
		dec_t r;
		logic [6:0] base;
		r = '0;
		base = 7'd52 + {5'd0, op[7:6]};
		r.sub = {1'b0, op[5:3]};
		if (pfx == 2'd0) begin
			r.form = (op[7:6] != 2'd0 && op[2:0] == 3'd6) ? 7'd110 + {5'd0, op[7:6]} : base;
			r.opa = reg8(op[2:0], 2'd0);
		end else if (op[2:0] == 3'd6) begin
			r.form = base + 7'd26; r.opa = ixreg(pfx); r.disp = d;
		end else begin
			r.form = base + 7'd22; r.opa = ixreg(pfx); r.opb = reg8(op[2:0], 2'd0);
			r.disp = d;
		end
		return r;
	endfunction

	function automatic dec_t decode_ed(input logic [7:0] op, input logic [15:0] imm);
		dec_t r;
		logic [2:0] y, z;
		logic [4:0] rr;
		y = op[5:3]; z = op[2:0];
		rr = (y == 3'd6) ? RG_F : reg8(y, 2'd0);
		r = '0;
		r.form = 7'd72;
		if (op[7:6] == 2'd1) begin
			case (z)
				3'd0: begin r.form = 7'd56; r.opa = rr; r.opb = RG_C; end
				3'd1: begin r.form = 7'd57; r.opa = RG_C; r.opb = rr; end
				3'd2: begin
					r.form = y[0] ? 7'd59 : 7'd58; r.opa = RG_HL;
					r.opb = rpair(y[2:1], 2'd0, 1'b0);
				end
				3'd3: begin
					r.form = y[0] ? 7'd61 : 7'd60; r.opa = rpair(y[2:1], 2'd0, 1'b0);
					r.imm = imm;
				end
				3'd4: r.form = 7'd62;
				3'd5: r.form = (y == 3'd1) ? 7'd64 : 7'd63;
				3'd6: begin r.form = 7'd65; r.sub = {1'b0, y}; end
				default: r.form = (y < 3'd6) ? 7'd66 + {4'd0, y} : 7'd72;
			endcase
		end else if (op[7:6] == 2'd2 && y[2] && !z[2]) begin
			r.form = 7'd73; r.sub = {y[1:0], z[1:0]};
		end
		return r;
	endfunction

endpackage

// ===== rtl/z80_instruction_predecoder_core.sv =====
// Z80 instruction predecoder: byte-stream prefix/group tracker with one result per instruction.
// Takes one code byte per cycle while in_stall is low; an instruction's result is registered in the cycle
// after its last byte is transferred, held in an output register that stalls independently
// of the input as long as the output is draining (input stalls only when that register is full
// and stalled). Prefix tracking, field splitting and decode form a single combinational pass
// between the held state and the result register. Writing start_address restarts decoding.
module z80_instruction_predecoder_core
	import z80pd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  code_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  form,
	output logic [4:0]  first_operand,
	output logic [4:0]  second_operand,
	output logic [3:0]  sub_code,
	output logic [15:0] immediate,
	output logic signed [7:0] displacement,
	output logic [2:0]  length,
	output logic [15:0] instr_address,
	output logic [15:0] jump_target
);

	phase_t      phase_q, phase_d;
	logic [1:0]  pfx_q, pfx_d;
	group_t      grp_q, grp_d;
	logic [7:0]  op_q, op_d, disp_q, disp_d, imml_q, imml_d;
	logic [2:0]  taken_q, taken_d;
	logic [15:0] start_q, addr_q, addr_d;

	logic        cfg_wr, acc, emit;
	logic [2:0]  len;
	logic [15:0] imm_w;
	logic [2:0]  need;
	dec_t        dec;
	logic [15:0] tgt;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_START) ? {16'd0, start_q} : 32'd0;
	assign cfg_wr = psel && penable && pwrite;

	assign in_stall = out_valid && out_stall;
	assign acc = in_valid && !in_stall;

	always_comb begin
		phase_d = phase_q; pfx_d = pfx_q; grp_d = grp_q; op_d = op_q;
		disp_d = disp_q; imml_d = imml_q; emit = 1'b0; imm_w = 16'd0;
		need = 3'd0;
		taken_d = (taken_q < 3'd7) ? taken_q + 3'd1 : taken_q;
		case (phase_q)
			PH_CB: begin
				if (pfx_q != 2'd0) begin disp_d = code_byte; phase_d = PH_CBOP; end
				else begin op_d = code_byte; emit = 1'b1; end
			end
			PH_CBOP: begin op_d = code_byte; emit = 1'b1; end
			PH_ED: begin
				op_d = code_byte;
				need = need_ed(code_byte);
				if (need[1:0] != 2'd0) phase_d = PH_IMMLO;
				else emit = 1'b1;
			end
			PH_DISP: begin
				disp_d = code_byte;
				need = (grp_q == GRP_ED) ? need_ed(op_q) : need_main(op_q, pfx_q);
				if (need[1:0] != 2'd0) phase_d = PH_IMMLO;
				else emit = 1'b1;
			end
			PH_IMMLO: begin
				imml_d = code_byte;
				need = (grp_q == GRP_ED) ? need_ed(op_q) : need_main(op_q, pfx_q);
				if (need[1:0] == 2'd2) phase_d = PH_IMMHI;
				else begin emit = 1'b1; imm_w = {8'd0, code_byte}; end
			end
			PH_IMMHI: begin emit = 1'b1; imm_w = {code_byte, imml_q}; end
			default: begin
				if (code_byte == BYTE_DD || code_byte == BYTE_FD) begin
					if (phase_q == PH_PREFIX) begin
						grp_d = GRP_MAIN; op_d = 8'd0; emit = 1'b1;
					end else begin
						pfx_d = (code_byte == BYTE_DD) ? 2'd1 : 2'd2;
						phase_d = PH_PREFIX;
					end
				end else if (code_byte == BYTE_CB) begin
					grp_d = GRP_CB; phase_d = PH_CB;
				end else if (code_byte == BYTE_ED) begin
					grp_d = GRP_ED; pfx_d = 2'd0; phase_d = PH_ED;
				end else begin
					grp_d = GRP_MAIN; op_d = code_byte;
					need = need_main(code_byte, pfx_q);
					if (need[2]) phase_d = PH_DISP;
					else if (need[1:0] != 2'd0) phase_d = PH_IMMLO;
					else emit = 1'b1;
				end
			end
		endcase
		if (grp_d == GRP_CB) dec = decode_cb(op_d, pfx_d, disp_d);
		else if (grp_d == GRP_ED) dec = decode_ed(op_d, imm_w);
		else dec = decode_main(op_d, pfx_d, disp_d, imm_w);
		len = taken_d;
		addr_d = addr_q + {13'd0, len};
		tgt = dec.rel ? addr_d + {{8{dec.disp[7]}}, dec.disp} : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST; pfx_q <= 2'd0; grp_q <= GRP_MAIN;
			op_q <= 8'd0; disp_q <= 8'd0; imml_q <= 8'd0; taken_q <= 3'd0;
			start_q <= 16'd0; addr_q <= 16'd0;
		end else if (cfg_wr && paddr == ADDR_START) begin
			start_q <= pwdata[15:0]; addr_q <= pwdata[15:0];
			phase_q <= PH_FIRST; pfx_q <= 2'd0; grp_q <= GRP_MAIN;
			op_q <= 8'd0; disp_q <= 8'd0; imml_q <= 8'd0; taken_q <= 3'd0;
		end else if (acc) begin
			if (emit) begin
				phase_q <= PH_FIRST; pfx_q <= 2'd0; grp_q <= GRP_MAIN;
				op_q <= 8'd0; disp_q <= 8'd0; imml_q <= 8'd0; taken_q <= 3'd0;
				addr_q <= addr_d;
			end else begin
				phase_q <= phase_d; pfx_q <= pfx_d; grp_q <= grp_d;
				op_q <= op_d; disp_q <= disp_d; imml_q <= imml_d; taken_q <= taken_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (acc && emit) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			form <= dec.form; first_operand <= dec.opa; second_operand <= dec.opb;
			sub_code <= dec.sub; immediate <= dec.imm; displacement <= dec.disp;
			length <= len; instr_address <= addr_q; jump_target <= tgt;
		end
	end

	// a prefix ahead of a four-byte ED op makes a five-byte transfer count
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (length != 3'd0 && length <= 3'd5))
		else $error("length out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled without pending result");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FIRST) |-> (taken_q == 3'd0))
		else $error("byte count not cleared");

endmodule
